[src/trgr_pkg.sv]
// Shared constants, types and the 5x7 glyph table for the text line glyph renderer.
package trgr_pkg;

  localparam int WIDTH      = 128;
  localparam int PAGES      = 8;
  localparam int GLYPH_COLS = 5;
  localparam int GAP_COLS   = 1;

  localparam int COL_W  = 8;
  localparam int ROW_W  = 3;
  localparam int CODE_W = 8;
  localparam int ADDR_W = 10;
  // row*WIDTH + column before truncation to the address width
  localparam int PROD_W = 12;

  localparam logic [COL_W-1:0] COL_PARK = {COL_W{1'b1}};

  typedef logic [GLYPH_COLS-1:0][7:0] glyph_t;

  // Cursor stage result handed to the output register.
  typedef struct packed {
    logic              fits;
    logic [ADDR_W-1:0] addr;
  } place_t;

  function automatic glyph_t mk(input logic [7:0] c0, input logic [7:0] c1,
                                input logic [7:0] c2, input logic [7:0] c3,
                                input logic [7:0] c4);
    mk = {c4, c3, c2, c1, c0};
  endfunction

  function automatic glyph_t glyph_lookup(input logic [CODE_W-1:0] code_in);
    logic [CODE_W-1:0] c;
    c = code_in;
    // fold lower case onto upper case
    if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
    case (c)
      8'h20: glyph_lookup = mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'h2E: glyph_lookup = mk(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
      8'h3A: glyph_lookup = mk(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
      8'h2D: glyph_lookup = mk(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
      8'h2B: glyph_lookup = mk(8'h08, 8'h08, 8'h3E, 8'h08, 8'h08);
      8'h3D: glyph_lookup = mk(8'h14, 8'h14, 8'h14, 8'h14, 8'h14);
      8'h2F: glyph_lookup = mk(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);
      8'h23: glyph_lookup = mk(8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14);
      8'h30: glyph_lookup = mk(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
      8'h31: glyph_lookup = mk(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
      8'h32: glyph_lookup = mk(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
      8'h33: glyph_lookup = mk(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
      8'h34: glyph_lookup = mk(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
      8'h35: glyph_lookup = mk(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
      8'h36: glyph_lookup = mk(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
      8'h37: glyph_lookup = mk(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
      8'h38: glyph_lookup = mk(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h39: glyph_lookup = mk(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
      8'h41: glyph_lookup = mk(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
      8'h42: glyph_lookup = mk(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h43: glyph_lookup = mk(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
      8'h44: glyph_lookup = mk(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
      8'h45: glyph_lookup = mk(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
      8'h46: glyph_lookup = mk(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
      8'h47: glyph_lookup = mk(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
      8'h48: glyph_lookup = mk(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
      8'h49: glyph_lookup = mk(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
      8'h4A: glyph_lookup = mk(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
      8'h4B: glyph_lookup = mk(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
      8'h4C: glyph_lookup = mk(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
      8'h4D: glyph_lookup = mk(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
      8'h4E: glyph_lookup = mk(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
      8'h4F: glyph_lookup = mk(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
      8'h50: glyph_lookup = mk(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
      8'h51: glyph_lookup = mk(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
      8'h52: glyph_lookup = mk(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
      8'h53: glyph_lookup = mk(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
      8'h54: glyph_lookup = mk(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
      8'h55: glyph_lookup = mk(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
      8'h56: glyph_lookup = mk(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
      8'h57: glyph_lookup = mk(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
      8'h58: glyph_lookup = mk(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
      8'h59: glyph_lookup = mk(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
      8'h5A: glyph_lookup = mk(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
      // anything else draws a question mark
      default: glyph_lookup = mk(8'h02, 8'h01, 8'h51, 8'h09, 8'h06);
    endcase
  endfunction

endpackage

[src/trgr_glyph_rom.sv]
// Glyph ROM: maps a character code to its five column bytes.
module trgr_glyph_rom (
  input  logic [trgr_pkg::CODE_W-1:0] code,
  output trgr_pkg::glyph_t            glyph
);

  assign glyph = trgr_pkg::glyph_lookup(code);

endmodule

[src/trgr_cursor.sv]
// Cursor: holds line row and column, decides fit and forms the start address.
module trgr_cursor (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic                       first_of_line,
  input  logic [trgr_pkg::ROW_W-1:0] text_row,
  output trgr_pkg::place_t           place
);

  logic [trgr_pkg::COL_W-1:0] cursor_column;
  logic [trgr_pkg::ROW_W-1:0] line_row;

  logic [trgr_pkg::COL_W-1:0]  col_eff;
  logic [trgr_pkg::ROW_W-1:0]  row_eff;
  logic [trgr_pkg::COL_W:0]    end_col;
  logic [trgr_pkg::COL_W:0]    adv_col;
  logic [trgr_pkg::PROD_W-1:0] addr_full;
  logic [trgr_pkg::COL_W-1:0]  cursor_column_next;

  always_comb begin
    if (first_of_line) begin
      row_eff = text_row;
      // a row beyond the last page parks the column so nothing fits
      if ({2'b00, text_row} < 5'(trgr_pkg::PAGES)) begin
        col_eff = '0;
      end else begin
        col_eff = trgr_pkg::COL_PARK;
      end
    end else begin
      row_eff = line_row;
      col_eff = cursor_column;
    end
    end_col   = {1'b0, col_eff} + (trgr_pkg::COL_W+1)'(trgr_pkg::GLYPH_COLS);
    adv_col   = end_col + (trgr_pkg::COL_W+1)'(trgr_pkg::GAP_COLS);
    addr_full = trgr_pkg::PROD_W'(row_eff) * trgr_pkg::PROD_W'(trgr_pkg::WIDTH)
              + trgr_pkg::PROD_W'(col_eff);
    place.fits = end_col < (trgr_pkg::COL_W+1)'(trgr_pkg::WIDTH);
    place.addr = addr_full[trgr_pkg::ADDR_W-1:0];
    if (!place.fits) begin
      cursor_column_next = col_eff;
    end else if (adv_col[trgr_pkg::COL_W]) begin
      cursor_column_next = trgr_pkg::COL_PARK;
    end else begin
      cursor_column_next = adv_col[trgr_pkg::COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      line_row      <= '0;
    end else if (step) begin
      cursor_column <= cursor_column_next;
      line_row      <= row_eff;
    end
  end

endmodule

[src/text_line_glyph_renderer.sv]
// Top level of the text line glyph renderer: input register, cursor, glyph ROM, result register.
//
// Renders a text line into a page-organized monochrome framebuffer, one character word
// per cycle. A word marked first_of_line latches text_row and restarts the column at zero;
// a row beyond the last page suppresses the whole line. Lower-case letters draw as upper
// case, and codes with no glyph draw a question mark. A character whose five columns fit
// before the right edge produces one result word: start_address (row*WIDTH + column, low
// ten bits) and glyph_col_0..4, bit 0 the top pixel; the column then advances by six to
// leave a blank gap column, which is not emitted. A character that does not fit produces
// nothing. The accepting edge loads the input register; when the result register is free
// or draining, the word moves on through the cursor and glyph ROM into the result
// register, and out_valid rises if it fits. Both stages move a word every cycle while
// out_ready is high, so the sustained rate is one character per clock; the cursor register
// is updated in the same cycle a word leaves the input register, which sets that figure.
module text_line_glyph_renderer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        first_of_line,
  input  logic [trgr_pkg::ROW_W-1:0]  text_row,
  input  logic [trgr_pkg::CODE_W-1:0] character_code,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [trgr_pkg::ADDR_W-1:0] start_address,
  output logic [7:0]                  glyph_col_0,
  output logic [7:0]                  glyph_col_1,
  output logic [7:0]                  glyph_col_2,
  output logic [7:0]                  glyph_col_3,
  output logic [7:0]                  glyph_col_4
);

  // input register
  logic                        s1_valid;
  logic                        s1_first;
  logic [trgr_pkg::ROW_W-1:0]  s1_row;
  logic [trgr_pkg::CODE_W-1:0] s1_code;

  logic             s1_adv;
  trgr_pkg::place_t place;
  trgr_pkg::glyph_t glyph;
  trgr_pkg::glyph_t out_glyph;

  // advance the input word whenever the result register is free or draining
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_first <= first_of_line;
      s1_row   <= text_row;
      s1_code  <= character_code;
    end
  end

  trgr_cursor u_cursor (
    .clk           (clk),
    .rst           (rst),
    .step          (s1_adv),
    .first_of_line (s1_first),
    .text_row      (s1_row),
    .place         (place)
  );

  trgr_glyph_rom u_rom (
    .code  (s1_code),
    .glyph (glyph)
  );

  // result register: load only characters that fit, drop the rest
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= place.fits;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && place.fits) begin
      start_address <= place.addr;
      out_glyph     <= glyph;
    end
  end

  assign glyph_col_0 = out_glyph[0];
  assign glyph_col_1 = out_glyph[1];
  assign glyph_col_2 = out_glyph[2];
  assign glyph_col_3 = out_glyph[3];
  assign glyph_col_4 = out_glyph[4];

endmodule

[sim/tb_text_line_glyph_renderer.sv]
// Self-checking testbench for the text line glyph renderer: predicted glyph words vs. output.
module tb_text_line_glyph_renderer;

  // Drop the run once this many cycles pass with no word moving on either side.
  localparam int STALL_LIMIT  = 5000;
  // The result register sits two stages behind the input; give it extra cycles to settle.
  localparam int DRAIN_CYCLES = 8;
  localparam int TOTAL_WORDS  = 1900;
  localparam int MAX_SHOWN    = 40;

  // Column 0 of the glyph is the leftmost byte of a literal.
  typedef logic [0:trgr_pkg::GLYPH_COLS-1][7:0] glyph_cols_t;

  typedef struct packed {
    logic [trgr_pkg::ADDR_W-1:0] addr;
    glyph_cols_t                 cols;
  } glyph_word_t;

  // Tracks the cursor and the page row, and queues the glyph word that each
  // accepted character should produce.
  class glyph_scoreboard;
    glyph_word_t pending_words[$];
    logic [trgr_pkg::COL_W-1:0] cursor_col;
    logic [trgr_pkg::ROW_W-1:0] cur_row;
    int errors;
    int checked;
    int clipped;
    int lines;

    function new();
      cursor_col = '0;
      cur_row    = '0;
      errors     = 0;
      checked    = 0;
      clipped    = 0;
      lines      = 0;
    endfunction

    // 5x7 font, columns left to right, bit 0 the top pixel.
    function glyph_cols_t glyph_of(logic [7:0] code);
      logic [7:0] c;
      c = code;
      if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
      case (c)
        8'h20: return 40'h00_00_00_00_00;
        8'h23: return 40'h14_7F_14_7F_14;
        8'h2B: return 40'h08_08_3E_08_08;
        8'h2D: return 40'h08_08_08_08_08;
        8'h2E: return 40'h00_60_60_00_00;
        8'h2F: return 40'h20_10_08_04_02;
        8'h3A: return 40'h00_36_36_00_00;
        8'h3D: return 40'h14_14_14_14_14;
        8'h30: return 40'h3E_51_49_45_3E;
        8'h31: return 40'h00_42_7F_40_00;
        8'h32: return 40'h42_61_51_49_46;
        8'h33: return 40'h21_41_45_4B_31;
        8'h34: return 40'h18_14_12_7F_10;
        8'h35: return 40'h27_45_45_45_39;
        8'h36: return 40'h3C_4A_49_49_30;
        8'h37: return 40'h01_71_09_05_03;
        8'h38: return 40'h36_49_49_49_36;
        8'h39: return 40'h06_49_49_29_1E;
        8'h41: return 40'h7E_11_11_11_7E;
        8'h42: return 40'h7F_49_49_49_36;
        8'h43: return 40'h3E_41_41_41_22;
        8'h44: return 40'h7F_41_41_22_1C;
        8'h45: return 40'h7F_49_49_49_41;
        8'h46: return 40'h7F_09_09_09_01;
        8'h47: return 40'h3E_41_49_49_7A;
        8'h48: return 40'h7F_08_08_08_7F;
        8'h49: return 40'h00_41_7F_41_00;
        8'h4A: return 40'h20_40_41_3F_01;
        8'h4B: return 40'h7F_08_14_22_41;
        8'h4C: return 40'h7F_40_40_40_40;
        8'h4D: return 40'h7F_02_0C_02_7F;
        8'h4E: return 40'h7F_04_08_10_7F;
        8'h4F: return 40'h3E_41_41_41_3E;
        8'h50: return 40'h7F_09_09_09_06;
        8'h51: return 40'h3E_41_51_21_5E;
        8'h52: return 40'h7F_09_19_29_46;
        8'h53: return 40'h46_49_49_49_31;
        8'h54: return 40'h01_01_7F_01_01;
        8'h55: return 40'h3F_40_40_40_3F;
        8'h56: return 40'h1F_20_40_20_1F;
        8'h57: return 40'h3F_40_38_40_3F;
        8'h58: return 40'h63_14_08_14_63;
        8'h59: return 40'h07_08_70_08_07;
        8'h5A: return 40'h61_51_49_45_43;
        default: return 40'h02_01_51_09_06;
      endcase
    endfunction

    function void note_char(bit first, logic [trgr_pkg::ROW_W-1:0] row, logic [7:0] code);
      glyph_word_t w;
      int          lin_addr;
      int          col_next;
      if (first) begin
        cur_row    = row;
        cursor_col = (row < trgr_pkg::PAGES) ? '0 : trgr_pkg::COL_PARK;
        lines++;
      end
      if (int'(cursor_col) + trgr_pkg::GLYPH_COLS >= trgr_pkg::WIDTH) begin
        clipped++;
        return;
      end
      lin_addr = int'(cur_row) * trgr_pkg::WIDTH + int'(cursor_col);
      w.addr   = lin_addr[trgr_pkg::ADDR_W-1:0];
      w.cols   = glyph_of(code);
      pending_words.push_back(w);
      col_next = int'(cursor_col) + trgr_pkg::GLYPH_COLS + trgr_pkg::GAP_COLS;
      cursor_col = (col_next > 255) ? trgr_pkg::COL_PARK : col_next[trgr_pkg::COL_W-1:0];
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_SHOWN) $display("MISMATCH: %s", msg);
    endtask

    task check_word(logic [trgr_pkg::ADDR_W-1:0] addr, glyph_cols_t cols);
      glyph_word_t w;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected glyph word at address %0d", addr));
        return;
      end
      w = pending_words.pop_front();
      checked++;
      if (addr !== w.addr)
        report_mismatch($sformatf("word %0d: start_address %0d, want %0d",
                                  checked, addr, w.addr));
      for (int k = 0; k < trgr_pkg::GLYPH_COLS; k++) begin
        if (cols[k] !== w.cols[k])
          report_mismatch($sformatf("word %0d (address %0d): glyph_col_%0d %02h, want %02h",
                                    checked, w.addr, k, cols[k], w.cols[k]));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        in_valid       = 1'b0;
  logic                        in_ready;
  logic                        first_of_line  = 1'b0;
  logic [trgr_pkg::ROW_W-1:0]  text_row       = '0;
  logic [trgr_pkg::CODE_W-1:0] character_code = '0;
  logic                        out_valid;
  logic                        out_ready      = 1'b0;
  logic [trgr_pkg::ADDR_W-1:0] start_address;
  logic [7:0]                  glyph_col_0;
  logic [7:0]                  glyph_col_1;
  logic [7:0]                  glyph_col_2;
  logic [7:0]                  glyph_col_3;
  logic [7:0]                  glyph_col_4;

  glyph_scoreboard sb = new();

  // Percent of cycles the sender holds back a word and the receiver stalls.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int chars_sent   = 0;
  int quiet_cycles = 0;

  text_line_glyph_renderer uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .first_of_line  (first_of_line),
    .text_row       (text_row),
    .character_code (character_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .start_address  (start_address),
    .glyph_col_0    (glyph_col_0),
    .glyph_col_1    (glyph_col_1),
    .glyph_col_2    (glyph_col_2),
    .glyph_col_3    (glyph_col_3),
    .glyph_col_4    (glyph_col_4)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall at random per the current phase; zero percent means always ready.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Monitor: sample both handshakes on the pre-edge values. An input word
  // cannot produce its result at the same edge, so the order of the two
  // checks below does not matter.
  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_char(first_of_line, text_row, character_code);
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        sb.check_word(start_address,
                      {glyph_col_0, glyph_col_1, glyph_col_2, glyph_col_3, glyph_col_4});
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d glyph words still due",
                 STALL_LIMIT, sb.pending_words.size());
        $display("tb_text_line_glyph_renderer: errors");
        $finish;
      end
    end
  end

  // Present one character word and hold it until accepted. Idle gaps come
  // first, so valid never drops while a word is waiting.
  task send_char(bit first, logic [trgr_pkg::ROW_W-1:0] row, logic [7:0] code);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    first_of_line  <= first;
    text_row       <= row;
    character_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  // Mostly printable text, with some codes from anywhere in the byte range.
  function logic [7:0] pick_code();
    if ($urandom_range(99) < 85) return 8'($urandom_range(8'h7E, 8'h20));
    return 8'($urandom_range(255));
  endfunction

  // One text line: a first word on a random row, then characters. Most lines
  // fit the width; some run past the right edge. A few noise words carry a
  // random first flag and, when it is set, break the line in the middle.
  task draw_random_line();
    int len;
    len = ($urandom_range(99) < 80) ? $urandom_range(21, 1) : $urandom_range(30, 22);
    send_char(1'b1, 3'($urandom_range(7)), pick_code());
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(99) < 3)
        send_char(1'($urandom_range(1)), 3'($urandom_range(7)), 8'($urandom_range(255)));
      else
        send_char(1'b0, 3'($urandom_range(7)), pick_code());
    end
  endtask

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    phase_idle  = '{0, 50, 0, 20};
    phase_stall = '{0, 0, 50, 20};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: draw before any line start (row 0 from column 0), with a row
    // value that must be ignored, then start a line on the last page.
    send_char(1'b0, 3'd0, 8'h41);
    send_char(1'b0, 3'd5, 8'h62);
    send_char(1'b1, 3'd7, 8'h5A);
    // Every punctuation glyph, digit ends and the letter range ends in both cases.
    send_char(1'b0, 3'd0, 8'h20);
    send_char(1'b0, 3'd0, 8'h2E);
    send_char(1'b0, 3'd0, 8'h3A);
    send_char(1'b0, 3'd0, 8'h2D);
    send_char(1'b0, 3'd0, 8'h2B);
    send_char(1'b0, 3'd0, 8'h3D);
    send_char(1'b0, 3'd0, 8'h2F);
    send_char(1'b0, 3'd0, 8'h23);
    send_char(1'b0, 3'd0, 8'h30);
    send_char(1'b0, 3'd0, 8'h39);
    send_char(1'b0, 3'd0, 8'h61);
    send_char(1'b0, 3'd0, 8'h7A);
    // Codes next to the letter ranges, NUL and codes outside ASCII draw the fallback.
    send_char(1'b0, 3'd0, 8'h00);
    send_char(1'b0, 3'd0, 8'hFF);
    send_char(1'b0, 3'd0, 8'h80);
    send_char(1'b0, 3'd0, 8'h40);
    send_char(1'b0, 3'd0, 8'h5B);
    send_char(1'b0, 3'd0, 8'h60);
    send_char(1'b0, 3'd0, 8'h7B);
    // Restart on row 0 mid-line.
    send_char(1'b1, 3'd0, 8'h3F);

    // Random lines under each handshake mix.
    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = phase_idle[p];
      rx_stall_pct = phase_stall[p];
      while (chars_sent < (p + 1) * TOTAL_WORDS / 4) draw_random_line();
    end

    in_valid     <= 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d characters over %0d lines, %0d glyph words checked",
             chars_sent, sb.lines, sb.checked);
    $display("run: %0d characters fell past the right edge, %0d mismatches",
             sb.clipped, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_text_line_glyph_renderer: clean");
    end else begin
      $display("tb_text_line_glyph_renderer: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
src/trgr_pkg.sv
src/trgr_glyph_rom.sv
src/trgr_cursor.sv
src/text_line_glyph_renderer.sv
sim/tb_text_line_glyph_renderer.sv
